### rtl/core/gpc_pkg.sv
`default_nettype none

package gpc_pkg;

    // Source kinds carried on the pixel channel
    localparam logic [1:0] KIND_MONO       = 2'd0;
    localparam logic [1:0] KIND_COLOUR     = 2'd1;
    localparam logic [1:0] KIND_BACKGROUND = 2'd2;

    localparam int          CHAN_W      = 8;
    localparam int          PIX_W       = 4 * CHAN_W;
    localparam int          PROD_W      = 2 * CHAN_W;
    localparam logic [7:0]  CHAN_MAX    = 8'hFF;
    localparam logic [15:0] BIAS_MONO   = 16'd127;
    localparam logic [15:0] BIAS_FILL   = 16'd128;

    // What the final stage puts on the output word
    typedef enum logic [1:0] {
        SEL_BLEND = 2'd0,
        SEL_SRC   = 2'd1,
        SEL_DEST  = 2'd2
    } t_sel;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [PROD_W-1:0] t_prod;

    // Round a tint product down to a premultiplied byte
    function automatic t_chan tint_round(input t_prod prod);
        t_prod sum;
        sum = prod + BIAS_MONO;
        return sum[PROD_W-1:CHAN_W];
    endfunction

    // s + ((d*inv + bias) >> 8), wrapped to one byte
    function automatic t_chan mix_chan(input t_chan s, input t_prod prod, input logic mono);
        t_prod sum;
        sum = prod + (mono ? BIAS_MONO : BIAS_FILL);
        return s + sum[PROD_W-1:CHAN_W];
    endfunction

endpackage

`default_nettype wire

### rtl/core/gpc_pix_if.sv
`default_nettype none

interface gpc_pix_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] dest_argb;
    logic [31:0] source_argb;
    logic [7:0]  coverage;
    logic [7:0]  tint_red;
    logic [7:0]  tint_green;
    logic [7:0]  tint_blue;

    modport source (
        output valid, kind, dest_argb, source_argb, coverage,
               tint_red, tint_green, tint_blue,
        input  ready
    );
    modport sink (
        input  valid, kind, dest_argb, source_argb, coverage,
               tint_red, tint_green, tint_blue,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/gpc_res_if.sv
`default_nettype none

interface gpc_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_argb;

    modport source (output valid, result_argb, input ready);
    modport sink   (input valid, result_argb, output ready);
endinterface

`default_nettype wire

### rtl/core/glyph_pixel_compositor_unit.sv
// Glyph pixel compositor: premultiplied src-over blend of one pixel per word.
//
// i_pix (sink) carries one destination pixel plus its source: a mono glyph
// coverage with an RGB tint, a premultiplied colour glyph, or a background
// fill colour. o_res (source) returns the composited ARGB pixel, one result
// word for every input word, in order.
//
// Pipeline: the word passes four registers: the input register at the
// accepting edge, then the tint multiply, the blend multiply, and the mix
// into the output register.
// Throughput: one word per clock. Every stage holds an 8x8 multiply or one
// add-and-select, so a new word enters each cycle the output is not stalled.
//
// Reset (i_rst_n low, synchronous) clears all stage valid bits; payload
// registers are left as they are.
// Stall: when o_res.valid is high and o_res.ready is low the whole pipeline
// holds, and i_pix.ready drops in the same cycle, so no word is lost or
// repeated. Bubbles travel as cleared valid bits and hold their place under
// a stall like any word; they are not squeezed out.
`default_nettype none

module glyph_pixel_compositor_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    gpc_pix_if.sink    i_pix,
    gpc_res_if.source  o_res
);
    import gpc_pkg::*;

    // Pipeline advance: the output register is free or being drained
    logic w_adv;

    // Stage 1: registered input word
    logic        r1_v;
    logic [1:0]  r1_kind;
    logic [31:0] r1_dest;
    logic [31:0] r1_src;
    t_chan       r1_cov;
    t_chan       r1_tr;
    t_chan       r1_tg;
    t_chan       r1_tb;

    // Stage 2: effective premultiplied source and output select
    logic        r2_v;
    logic [31:0] r2_src;
    logic [31:0] r2_dest;
    logic        r2_mono;
    t_sel        r2_sel;

    // Stage 3: destination products
    logic        r3_v;
    t_prod       r3_prod [4];
    logic [31:0] r3_src;
    logic [31:0] r3_dest;
    logic        r3_mono;
    t_sel        r3_sel;

    // Output register
    logic        r_out_v;
    logic [31:0] r_out;

    // Stage 1 -> 2 combinational
    logic [31:0] n2_src;
    t_sel        n2_sel;
    t_chan       w_sa;

    // Stage 3 -> out combinational
    logic [31:0] n_out;

    assign w_adv       = !r_out_v || o_res.ready;
    assign i_pix.ready = w_adv;
    assign o_res.valid = r_out_v;
    assign o_res.result_argb = r_out;

    // Valid bits advance only with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r1_v    <= i_pix.valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_out_v <= r3_v;
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_kind <= i_pix.kind;
            r1_dest <= i_pix.dest_argb;
            r1_src  <= i_pix.source_argb;
            r1_cov  <= i_pix.coverage;
            r1_tr   <= i_pix.tint_red;
            r1_tg   <= i_pix.tint_green;
            r1_tb   <= i_pix.tint_blue;
        end
    end

    // Tint the mono colour and pick the path: full blend, source
    // overwrite at opaque alpha, or pass the destination through for a
    // transparent colour glyph and for the unused kind.
    assign w_sa = r1_src[31:24];

    always_comb begin
        n2_src = r1_src;
        n2_sel = SEL_DEST;
        unique case (r1_kind)
            KIND_MONO: begin
                n2_src = {r1_cov,
                          tint_round(t_prod'(r1_tr) * t_prod'(r1_cov)),
                          tint_round(t_prod'(r1_tg) * t_prod'(r1_cov)),
                          tint_round(t_prod'(r1_tb) * t_prod'(r1_cov))};
                n2_sel = SEL_BLEND;
            end
            KIND_COLOUR: begin
                if (w_sa == CHAN_MAX) begin
                    n2_sel = SEL_SRC;
                end else if (w_sa != '0) begin
                    n2_sel = SEL_BLEND;
                end else begin
                    n2_sel = SEL_DEST;
                end
            end
            KIND_BACKGROUND: begin
                n2_sel = (w_sa == CHAN_MAX) ? SEL_SRC : SEL_BLEND;
            end
            default: begin
                n2_sel = SEL_DEST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_src  <= n2_src;
            r2_dest <= r1_dest;
            r2_mono <= (r1_kind == KIND_MONO);
            r2_sel  <= n2_sel;
        end
    end

    // Scale each destination byte by the inverse source alpha
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 4; c++) begin
                r3_prod[c] <= t_prod'(r2_dest[c*CHAN_W +: CHAN_W])
                            * t_prod'(CHAN_MAX - r2_src[31:24]);
            end
            r3_src  <= r2_src;
            r3_dest <= r2_dest;
            r3_mono <= r2_mono;
            r3_sel  <= r2_sel;
        end
    end

    // Round, add the source and choose the output word
    always_comb begin
        n_out = r3_dest;
        unique case (r3_sel)
            SEL_BLEND: begin
                for (int c = 0; c < 4; c++) begin
                    n_out[c*CHAN_W +: CHAN_W] =
                        mix_chan(r3_src[c*CHAN_W +: CHAN_W], r3_prod[c], r3_mono);
                end
            end
            SEL_SRC:  n_out = r3_src;
            SEL_DEST: n_out = r3_dest;
            default:  n_out = r3_dest;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // Reset empties every stage, the output stage included
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid && !r1_v && !r2_v && !r3_v)
        else $error("pipeline valid bits not cleared by reset");

    // A held output word freezes the input side too
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_pix.ready)
        else $error("input accepted while output stalled");

    // A pass-through word leaves the destination untouched
    a_dest_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && w_adv && r3_sel == SEL_DEST) |=> (o_res.result_argb == $past(r3_dest)))
        else $error("pass-through word altered");

    // A word in the last stage reaches the output on advance
    a_valid_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r3_v) |=> o_res.valid)
        else $error("word lost between last stage and output");

endmodule

`default_nettype wire

### tb/tb_glyph_pixel_compositor_unit.sv
`timescale 1ns / 100ps

module tb_glyph_pixel_compositor_unit;

    import gpc_pkg::*;

    // Kind code that the block must pass through untouched
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Cycles with no word moving on either channel before the run is abandoned
    localparam int IDLE_LIMIT      = 4000;
    // Drain time after the last result: longer than the four-stage pipeline
    localparam int DRAIN_CYCLES    = 16;
    localparam int RANDOM_WORDS    = 1330;
    // Random words in this index range run with both sides free of idling
    localparam int QUIET_FIRST     = 400;
    localparam int QUIET_LAST      = 599;
    localparam int MAX_PRINTED     = 40;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] dest;
        logic [31:0] src;
        logic [7:0]  cov;
        logic [7:0]  tr;
        logic [7:0]  tg;
        logic [7:0]  tb;
        bit          typed;     // want holds a hand-written result
        logic [31:0] want;
    } t_pixel_word;

    logic i_clk;
    logic i_rst_n;

    gpc_pix_if pix_ch ();
    gpc_res_if res_ch ();

    glyph_pixel_compositor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    t_pixel_word  directed_words[$];
    logic [31:0]  pending_pixels[$];
    int           mismatch_count;
    int           idle_cycles;
    bit           quiet;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Src-over of one premultiplied pixel onto another: per channel
    // s + ((d*(255-a) + bias) >> 8), each sum kept to its low byte.
    function automatic logic [31:0] blend_src_over(input logic [31:0] s,
                                                   input logic [31:0] d,
                                                   input logic [15:0] bias);
        logic [15:0] inv;
        logic [15:0] prod;
        logic [31:0] acc;
        acc = '0;
        inv = 16'(CHAN_MAX) - 16'(s[31:24]);
        for (int ch = 0; ch < 4; ch++) begin
            prod = 16'(d[ch*8 +: 8]) * inv + bias;
            acc[ch*8 +: 8] = s[ch*8 +: 8] + prod[15:8];
        end
        return acc;
    endfunction

    function automatic logic [31:0] composite_pixel(input t_pixel_word w);
        logic [31:0] tinted;
        logic [15:0] prod;
        logic [7:0]  tint[3];
        logic [7:0]  alpha;
        tint[0] = w.tb;
        tint[1] = w.tg;
        tint[2] = w.tr;
        alpha   = w.src[31:24];
        case (w.kind)
            KIND_MONO: begin
                // Premultiply the tint by coverage, then blend with the mono bias
                tinted[31:24] = w.cov;
                for (int ch = 0; ch < 3; ch++) begin
                    prod = 16'(tint[ch]) * 16'(w.cov) + BIAS_MONO;
                    tinted[ch*8 +: 8] = prod[15:8];
                end
                return blend_src_over(tinted, w.dest, BIAS_MONO);
            end
            KIND_COLOUR: begin
                if (alpha == CHAN_MAX) return w.src;
                if (alpha == 8'd0)     return w.dest;
                return blend_src_over(w.src, w.dest, BIAS_FILL);
            end
            KIND_BACKGROUND: begin
                // No pass-through at zero alpha here: the blend still rounds
                if (alpha == CHAN_MAX) return w.src;
                return blend_src_over(w.src, w.dest, BIAS_FILL);
            end
            default: return w.dest;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch, %s: got %08h want %08h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Mostly back-to-back, often a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_row(input logic [1:0] kind, input logic [31:0] dest,
                           input logic [31:0] src, input logic [7:0] cov,
                           input logic [7:0] tr, input logic [7:0] tg,
                           input logic [7:0] tb, input bit typed,
                           input logic [31:0] want);
        t_pixel_word w;
        w.kind  = kind;
        w.dest  = dest;
        w.src   = src;
        w.cov   = cov;
        w.tr    = tr;
        w.tg    = tg;
        w.tb    = tb;
        w.typed = typed;
        w.want  = want;
        directed_words.push_back(w);
    endtask

    // Present one word at the falling edge, hold it until the rising edge
    // that takes it, then queue its expected result. Returns at a falling edge.
    task automatic send_pixel(input t_pixel_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_ch.valid       = 1'b1;
        pix_ch.kind        = w.kind;
        pix_ch.dest_argb   = w.dest;
        pix_ch.source_argb = w.src;
        pix_ch.coverage    = w.cov;
        pix_ch.tint_red    = w.tr;
        pix_ch.tint_green  = w.tg;
        pix_ch.tint_blue   = w.tb;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        pending_pixels.push_back(w.typed ? w.want : composite_pixel(w));
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall at random, check every word taken
    // ------------------------------------------------------------------

    initial begin
        int gap;
        res_ch.ready = 1'b0;
        repeat (10) @(negedge i_clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with nothing pending", res_ch.result_argb, '0);
            end else begin
                if (res_ch.result_argb !== pending_pixels[0])
                    report_mismatch("result_argb", res_ch.result_argb, pending_pixels[0]);
                void'(pending_pixels.pop_front());
            end
        end
    end

    // Abandon the run if no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        t_pixel_word w;
        logic [7:0]  alpha;
        int          r;

        mismatch_count     = 0;
        idle_cycles        = 0;
        quiet              = 1'b0;
        i_rst_n            = 1'b0;
        pix_ch.valid       = 1'b0;
        pix_ch.kind        = KIND_MONO;
        pix_ch.dest_argb   = '0;
        pix_ch.source_argb = '0;
        pix_ch.coverage    = '0;
        pix_ch.tint_red    = '0;
        pix_ch.tint_green  = '0;
        pix_ch.tint_blue   = '0;

        // Directed rows; hand results only where they follow at a glance
        // kind, dest, src, cov, red, green, blue, typed, want
        // Unused kind: dest passes, every other field ignored
        add_row(KIND_UNUSED,     32'h12345678, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                1, 32'h12345678);
        add_row(KIND_UNUSED,     32'hFFFFFFFF, 32'h00000000, 8'h00, 8'h00, 8'h00, 8'h00,
                1, 32'hFFFFFFFF);
        // Colour glyph at full alpha replaces, at zero alpha passes dest
        add_row(KIND_COLOUR,     32'h00000000, 32'hFFFFFFFF, 8'h00, 8'h00, 8'h00, 8'h00,
                1, 32'hFFFFFFFF);
        add_row(KIND_COLOUR,     32'hA5C3E1F0, 32'hFF102030, 8'hFF, 8'h55, 8'hAA, 8'h5A,
                1, 32'hFF102030);
        add_row(KIND_COLOUR,     32'hFFFFFFFF, 32'h00FFFFFF, 8'h80, 8'h11, 8'h22, 8'h33,
                1, 32'hFFFFFFFF);
        add_row(KIND_COLOUR,     32'h89ABCDEF, 32'h00000000, 8'h00, 8'h00, 8'h00, 8'h00,
                1, 32'h89ABCDEF);
        // Background at full alpha replaces; at zero alpha it still rounds
        add_row(KIND_BACKGROUND, 32'h00000000, 32'hFFABCDEF, 8'h00, 8'h00, 8'h00, 8'h00,
                1, 32'hFFABCDEF);
        add_row(KIND_BACKGROUND, 32'hFFFFFFFF, 32'h00000000, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                1, 32'hFEFEFEFE);
        add_row(KIND_BACKGROUND, 32'h00000000, 32'h00000000, 8'h00, 8'h00, 8'h00, 8'h00,
                1, 32'h00000000);
        // Mono glyph at full coverage: dest drops out, the tint rounds down
        add_row(KIND_MONO,       32'hFFFFFFFF, 32'h00000000, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                1, 32'hFFFEFEFE);
        add_row(KIND_MONO,       32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                1, 32'hFF000000);
        // Channel overflow from a source that is not premultiplied
        add_row(KIND_COLOUR,     32'hFFFFFFFF, 32'h80FFFFFF, 8'h00, 8'h00, 8'h00, 8'h00,
                1, 32'hFF7E7E7E);
        add_row(KIND_BACKGROUND, 32'hFFFFFFFF, 32'hFEFFFFFF, 8'h00, 8'h00, 8'h00, 8'h00,
                0, '0);
        // Predictor-checked corners
        add_row(KIND_MONO,       32'h12345678, 32'hFFFFFFFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                0, '0);
        add_row(KIND_MONO,       32'hFFFFFFFF, 32'h00000000, 8'h01, 8'hFF, 8'h80, 8'h01,
                0, '0);
        add_row(KIND_MONO,       32'h80808080, 32'h5A5A5A5A, 8'h80, 8'h7F, 8'h80, 8'hFF,
                0, '0);
        add_row(KIND_MONO,       32'h00000000, 32'h00000000, 8'hFE, 8'hC0, 8'h40, 8'h20,
                0, '0);
        add_row(KIND_COLOUR,     32'hFFFFFFFF, 32'h01010101, 8'h00, 8'h00, 8'h00, 8'h00,
                0, '0);
        add_row(KIND_COLOUR,     32'h7F7F7F7F, 32'hFEFEFEFE, 8'h00, 8'h00, 8'h00, 8'h00,
                0, '0);
        add_row(KIND_COLOUR,     32'hC0FFEE11, 32'h80402010, 8'hAA, 8'h55, 8'hAA, 8'h55,
                0, '0);
        add_row(KIND_BACKGROUND, 32'hFFFFFFFF, 32'h01000000, 8'h00, 8'h00, 8'h00, 8'h00,
                0, '0);
        add_row(KIND_BACKGROUND, 32'h12345678, 32'h7F3F1F0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                0, '0);

        // Hold reset, then release it at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_words[i])
            send_pixel(directed_words[i]);

        // Random words: mostly premultiplied sources, alpha and coverage
        // biased to their end points, a few non-premultiplied and unused kinds
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            quiet = (n >= QUIET_FIRST) && (n <= QUIET_LAST);
            r = $urandom_range(0, 99);
            if (r < 35)      w.kind = KIND_MONO;
            else if (r < 65) w.kind = KIND_COLOUR;
            else if (r < 95) w.kind = KIND_BACKGROUND;
            else             w.kind = KIND_UNUSED;
            w.dest = $urandom;
            r = $urandom_range(0, 9);
            if (r == 0)      alpha = 8'h00;
            else if (r == 1) alpha = CHAN_MAX;
            else             alpha = 8'($urandom_range(0, 255));
            w.src[31:24] = alpha;
            for (int ch = 0; ch < 3; ch++) begin
                if ($urandom_range(0, 9) == 0)
                    w.src[ch*8 +: 8] = 8'($urandom_range(0, 255));
                else
                    w.src[ch*8 +: 8] = 8'($urandom_range(0, int'(alpha)));
            end
            r = $urandom_range(0, 9);
            if (r == 0)      w.cov = 8'h00;
            else if (r == 1) w.cov = CHAN_MAX;
            else             w.cov = 8'($urandom_range(0, 255));
            w.tr    = 8'($urandom_range(0, 255));
            w.tg    = 8'($urandom_range(0, 255));
            w.tb    = 8'($urandom_range(0, 255));
            w.typed = 1'b0;
            w.want  = '0;
            send_pixel(w);
        end
        quiet        = 1'b0;
        pix_ch.valid = 1'b0;

        // Drain: wait for every pending result, then catch any stray word
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_pixels.size() != 0)
            report_mismatch("result never arrived", '0, pending_pixels[0]);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
